/* rtl/core/alru_pkg.sv */
// shared types and constants for the lru timestamp cache directory
package alru_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 32;
    localparam int TS_W    = 32;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = $clog2(ENTRIES);

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] file_key;
        logic [KEY_W-1:0] message_key;
        logic [TS_W-1:0]  now;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // search state handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic [TS_W-1:0]  oldest;
        logic [IDX_W-1:0] min_idx;
    } t_token;

    // update broadcast to every cell at the end of a request
    typedef struct packed {
        logic             en;
        logic             fill;
        logic [IDX_W-1:0] idx;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

/* rtl/core/assoc_cache_lru_timestamp_top.sv */
// top level of the fully associative cache directory with timestamp lru
// Each request is taken in the idle state; the search state then walks the row of entry
// cells one cell per cycle, and the commit state updates the chosen entry and loads the
// result register. One request is in flight at a time; the next is taken in the cycle
// after the result is registered, even while that result waits to be taken. A result
// still waiting when the next search ends holds that update until it is taken. A lookup
// returns the lowest matching valid entry and restamps it; a fill replaces the lowest
// entry holding the smallest timestamp older than now, or entry 0 when none is older.
module assoc_cache_lru_timestamp_top
    import alru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    t_in_item         r_req;
    logic             r_out_valid;
    t_out_item        r_out;
    t_token           w_chain [ENTRIES+1];
    t_token           w_last;
    t_wr              w_wr;
    logic             w_accept;
    logic             w_fire;
    logic             w_scan_end;
    logic             w_is_fill;

    assign w_last     = w_chain[ENTRIES];
    assign w_is_fill  = (r_req.func == FUNC_FILL);
    assign w_scan_end = (r_cnt == CNT_W'(ENTRIES - 1));

    // chain seed
    always_comb begin
        w_chain[0].found   = 1'b0;
        w_chain[0].hit_idx = '0;
        w_chain[0].oldest  = r_req.now;
        w_chain[0].min_idx = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        alru_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_index       (IDX_W'(g)),
            .i_file_key    (r_req.file_key),
            .i_message_key (r_req.message_key),
            .i_now         (r_req.now),
            .i_token       (w_chain[g]),
            .i_wr          (w_wr),
            .o_token       (w_chain[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_fire     = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_SCAN:   o_in_stall = 1'b1;
            ST_COMMIT: w_fire     = !r_out_valid || !i_out_stall;
            default:   o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_wr.en   = w_fire && (w_is_fill || w_last.found);
        w_wr.fill = w_is_fill;
        w_wr.idx  = w_is_fill ? w_last.min_idx : w_last.hit_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cnt <= '0;
            r_req <= i_in_item;
        end else if (r_state == ST_SCAN) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.hit <= !w_is_fill && w_last.found;
            if (w_is_fill) begin
                r_out.slot <= SLOT_W'(w_last.min_idx);
            end else if (w_last.found) begin
                r_out.slot <= SLOT_W'(w_last.hit_idx);
            end else begin
                r_out.slot <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("transfer did not start a fresh scan");

    a_commit_after_full_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (n_state == ST_COMMIT) |-> w_scan_end)
        else $error("commit before the search crossed every cell");

    a_fill_never_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_is_fill |=> o_out_valid && !o_out_item.hit)
        else $error("fill reported a hit");

endmodule

/* rtl/core/alru_cell.sv */
// one directory entry plus its stage of the search chain
module alru_cell
    import alru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic [KEY_W-1:0] i_file_key,
    input  logic [KEY_W-1:0] i_message_key,
    input  logic [TS_W-1:0]  i_now,
    input  t_token           i_token,
    input  t_wr              i_wr,
    output t_token           o_token
);

    logic             r_valid;
    logic [TS_W-1:0]  r_stamp;
    logic [KEY_W-1:0] r_file_tag;
    logic [KEY_W-1:0] r_message_tag;
    t_token           r_token;
    t_token           n_token;
    logic             w_match;
    logic             w_sel;

    assign w_match = r_valid && (r_file_tag == i_file_key) && (r_message_tag == i_message_key);
    assign w_sel   = i_wr.en && (i_wr.idx == i_index);

    always_comb begin
        n_token = i_token;
        // first match along the chain wins
        if (!i_token.found && w_match) begin
            n_token.found   = 1'b1;
            n_token.hit_idx = i_index;
        end else begin
            n_token.found   = i_token.found | w_match;
        end
        // strictly older keeps the lowest index on ties
        if (r_stamp < i_token.oldest) begin
            n_token.oldest  = r_stamp;
            n_token.min_idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token <= n_token;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (w_sel) begin
            r_stamp <= i_now;
            if (i_wr.fill) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.fill) begin
            r_file_tag    <= i_file_key;
            r_message_tag <= i_message_key;
        end
    end

    assign o_token = r_token;

endmodule

/* tb/sv/assoc_cache_lru_timestamp_top_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the timestamp lru cache directory
module assoc_cache_lru_timestamp_top_tb;
    import alru_pkg::*;

    localparam int RANDOM_REQS    = 1450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = ENTRIES + 16;
    localparam int POOL_MAX       = 100;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // directory copy kept by the testbench
    logic             dir_valid [ENTRIES];
    logic [KEY_W-1:0] dir_file  [ENTRIES];
    logic [KEY_W-1:0] dir_msg   [ENTRIES];
    logic [TS_W-1:0]  dir_stamp [ENTRIES];

    t_in_item  request_q[$];
    t_out_item expected_slot_q[$];

    int        mismatches  = 0;
    int        gap_left    = 0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    logic [6:0] stall_phase = '0;
    logic [1:0] stall_mode  = '0;
    logic       req_fire;
    logic       rsp_fire;
    t_out_item  want;

    always #2 i_clk = ~i_clk;

    assoc_cache_lru_timestamp_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // applies one request to the directory copy and returns the slot it reports
    function automatic t_out_item cache_access(input t_in_item req);
        t_out_item       res;
        logic [TS_W-1:0] oldest;
        int              victim;
        logic            found;
        res   = '0;
        found = 1'b0;
        if (req.func == FUNC_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && dir_valid[i] && dir_file[i] == req.file_key &&
                    dir_msg[i] == req.message_key) begin
                    found        = 1'b1;
                    dir_stamp[i] = req.now;
                    res.hit      = 1'b1;
                    res.slot     = SLOT_W'(i);
                end
            end
        end else begin
            oldest = req.now;
            victim = 0;
            // strict compare keeps the lowest entry among equal stamps
            for (int i = 0; i < ENTRIES; i++) begin
                if (dir_stamp[i] < oldest) begin
                    oldest = dir_stamp[i];
                    victim = i;
                end
            end
            dir_valid[victim] = 1'b1;
            dir_file[victim]  = req.file_key;
            dir_msg[victim]   = req.message_key;
            dir_stamp[victim] = req.now;
            res.slot          = SLOT_W'(victim);
        end
        return res;
    endfunction

    task automatic add_req(input logic func, input logic [KEY_W-1:0] fkey,
                           input logic [KEY_W-1:0] mkey, input logic [TS_W-1:0] stamp);
        t_in_item req;
        req.func        = func;
        req.file_key    = fkey;
        req.message_key = mkey;
        req.now         = stamp;
        request_q.push_back(req);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // request side: bursts with random gaps, payload held until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            req_fire = in_valid && !in_stall;
            if (req_fire) begin
                expected_slot_q.push_back(cache_access(in_item));
                void'(request_q.pop_front());
            end
            if (!in_valid || req_fire) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item  <= request_q[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90)
                                                                  : $urandom_range(0, 2);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each transfer, stall on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_slot_q.size() == 0) begin
                    report_mismatch("unexpected result", {25'b0, out_item}, '0);
                end else begin
                    want = expected_slot_q.pop_front();
                    if (out_item.hit !== want.hit)
                        report_mismatch("hit", 32'(out_item.hit), 32'(want.hit));
                    if (out_item.slot !== want.slot)
                        report_mismatch("slot", 32'(out_item.slot), 32'(want.slot));
                end
            end
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == 7'h7f)
                stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 2) == 0);
                2'd2: out_stall <= stall_phase[4];
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            rsp_fire = out_valid && !out_stall;
            if ((in_valid && !in_stall) || rsp_fire) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [TS_W-1:0]  clock_now;
        logic [KEY_W-1:0] pool_file[$];
        logic [KEY_W-1:0] pool_msg[$];
        logic [KEY_W-1:0] fk;
        logic [KEY_W-1:0] mk;
        int               target;
        int               pick;
        int               roll;

        for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_file[i]  = '0;
            dir_msg[i]   = '0;
            dir_stamp[i] = '0;
        end

        // empty directory, then a fill with nothing older than now
        add_req(FUNC_LOOKUP, '0, '0, '0);
        add_req(FUNC_FILL,   '0, '0, '0);
        add_req(FUNC_LOOKUP, '0, '0, '0);
        // equal stamps everywhere: lowest entry is the victim
        add_req(FUNC_FILL,   '1, '1, 32'd10);
        add_req(FUNC_FILL,   '1, '0, 32'd10);
        add_req(FUNC_FILL,   '0, '1, 32'd11);
        add_req(FUNC_LOOKUP, '1, '1, 32'd12);
        add_req(FUNC_LOOKUP, '1, 32'hffff_fffe, 32'd12);
        // same key filled twice, the lower slot answers
        add_req(FUNC_FILL,   '1, '1, 32'd13);
        add_req(FUNC_LOOKUP, '1, '1, 32'd14);
        add_req(FUNC_LOOKUP, '0, '1, 32'hffff_ffff);
        add_req(FUNC_FILL,   32'ha5a5_5a5a, 32'h5a5a_a5a5, 32'hffff_ffff);
        // time going backwards lands on slot 0
        add_req(FUNC_FILL,   32'h1234_5678, 32'h8765_4321, '0);
        add_req(FUNC_LOOKUP, '0, '0, 32'd20);
        add_req(FUNC_LOOKUP, 32'h1234_5678, 32'h8765_4321, 32'd20);
        add_req(FUNC_LOOKUP, 32'ha5a5_5a5a, 32'h5a5a_a5a5, 32'd20);
        add_req(FUNC_FILL,   32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
        add_req(FUNC_LOOKUP, 32'h0000_0001, 32'h8000_0000, 32'h8000_0001);
        add_req(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001);

        clock_now = 32'd100;
        target    = request_q.size() + RANDOM_REQS;
        while (request_q.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_now = $urandom;
            else if (roll < 4)
                clock_now = 32'hffff_ffff - $urandom_range(0, 40);
            else
                clock_now = clock_now + $urandom_range(0, 2);

            roll = $urandom_range(0, 99);
            if (roll < 45 && pool_file.size() > 0) begin
                pick = $urandom_range(0, pool_file.size() - 1);
                add_req(FUNC_LOOKUP, pool_file[pick], pool_msg[pick], clock_now);
            end else if (roll < 70) begin
                // miss followed by the fill after the backing fetch
                fk = $urandom;
                mk = $urandom;
                if (pool_file.size() > 0 && $urandom_range(0, 3) == 0)
                    fk = pool_file[$urandom_range(0, pool_file.size() - 1)];
                add_req(FUNC_LOOKUP, fk, mk, clock_now);
                clock_now = clock_now + $urandom_range(0, 1);
                add_req(FUNC_FILL, fk, mk, clock_now);
                pool_file.push_back(fk);
                pool_msg.push_back(mk);
                if (pool_file.size() > POOL_MAX) begin
                    void'(pool_file.pop_front());
                    void'(pool_msg.pop_front());
                end
            end else if (roll < 85) begin
                if (pool_file.size() > 0 && $urandom_range(0, 1) == 0) begin
                    pick = $urandom_range(0, pool_file.size() - 1);
                    add_req(FUNC_FILL, pool_file[pick], pool_msg[pick], clock_now);
                end else begin
                    add_req(FUNC_FILL, $urandom, $urandom, clock_now);
                end
            end else begin
                fk = $urandom;
                if (pool_file.size() > 0 && $urandom_range(0, 1) == 0)
                    fk = pool_file[$urandom_range(0, pool_file.size() - 1)];
                add_req(FUNC_LOOKUP, fk, $urandom, clock_now);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (request_q.size() > 0 || in_valid || expected_slot_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/alru_pkg.sv
rtl/core/alru_cell.sv
rtl/core/assoc_cache_lru_timestamp_top.sv
tb/sv/assoc_cache_lru_timestamp_top_tb.sv
